// ===== rtl/core/htu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htu_pkg
// Types and constants shared by the host time unwrap and extrapolate core.
// ----------------------------------------------------------------------------
package htu_pkg;

  // host stamp tick length in microseconds
  localparam int unsigned TICK_US = 10;

  // freeze timeout after reset, in microseconds
  localparam logic [31:0] FREEZE_TIMEOUT_RST = 32'd200000;

  // item kinds
  typedef enum logic [1:0] {
    OP_STAMP = 2'd0,
    OP_TICK  = 2'd1,
    OP_RESET = 2'd2
  } htu_op_t;

  // input item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] frame_counter;
    logic [31:0] raw_stamp;
    logic [63:0] local_time_us;
  } htu_in_t;

  // result item
  typedef struct packed {
    logic        stamp_accepted;
    logic [63:0] sim_time_us;
    logic        is_frozen;
    logic        has_base;
  } htu_out_t;

  // configuration write data
  typedef logic [31:0] htu_cfg_t;

  // stamp ticks times the tick length, as shift and add
  function automatic logic [35:0] ticks_to_us(input logic [31:0] ticks);
    logic [35:0] t;
    begin
      t = {4'd0, ticks};
      return (t << 3) + (t << 1);
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/htu_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htu_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface htu_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/htu_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htu_in_reg
// Input register: holds one item until the engine consumes it.
// ----------------------------------------------------------------------------
module htu_in_reg
  import htu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  htu_chan_if.sink      in_ch,
  input  wire logic     advance,
  output logic          item_valid,
  output htu_in_t       item
);

  // accept when empty or when the held item moves on this cycle
  assign in_ch.ready = !item_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item <= in_ch.payload;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/htu_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htu_engine
// Session state, stamp unwrap, freeze test and sim time for one item.
// ----------------------------------------------------------------------------
module htu_engine
  import htu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire htu_cfg_t cfg_data,
  input  wire logic     advance,
  input  wire htu_in_t  item,
  output htu_out_t      result
);

  // timeout register
  logic [31:0] freeze_timeout_us;

  // session state
  logic        base_valid;
  logic [31:0] last_frame;
  logic [31:0] last_raw;
  logic [63:0] base_sim_us;
  logic [63:0] base_received_us;
  logic        frozen_flag;

  logic        base_valid_next;
  logic [31:0] last_frame_next;
  logic [31:0] last_raw_next;
  logic [63:0] base_sim_us_next;
  logic [63:0] base_received_us_next;
  logic        frozen_flag_next;

  logic [31:0] delta_ticks;
  logic [63:0] elapsed_us;
  logic [63:0] extrap_us;
  logic [63:0] stamp_sim_us;
  logic        stamp_ok;
  logic        timed_out;

  // shared arithmetic
  always_comb begin
    delta_ticks  = item.raw_stamp - last_raw;
    elapsed_us   = item.local_time_us - base_received_us;
    extrap_us    = base_sim_us + elapsed_us;
    stamp_ok     = !(base_valid && (item.frame_counter < last_frame));
    timed_out    = elapsed_us > {32'd0, freeze_timeout_us};
    stamp_sim_us = base_valid ? base_sim_us + {28'd0, ticks_to_us(delta_ticks)}
                              : {28'd0, ticks_to_us(item.raw_stamp)};
  end

  // next state and result
  always_comb begin
    base_valid_next       = base_valid;
    last_frame_next       = last_frame;
    last_raw_next         = last_raw;
    base_sim_us_next      = base_sim_us;
    base_received_us_next = base_received_us;
    frozen_flag_next      = frozen_flag;
    result.stamp_accepted = 1'b0;
    result.sim_time_us    = !base_valid ? 64'd0 : (frozen_flag ? base_sim_us : extrap_us);

    unique case (item.opcode)
      OP_STAMP: begin
        if (stamp_ok) begin
          base_valid_next       = 1'b1;
          last_frame_next       = item.frame_counter;
          last_raw_next         = item.raw_stamp;
          base_sim_us_next      = stamp_sim_us;
          base_received_us_next = item.local_time_us;
          frozen_flag_next      = 1'b0;
          result.stamp_accepted = 1'b1;
          result.sim_time_us    = stamp_sim_us;
        end
      end
      OP_TICK: begin
        if (base_valid && timed_out) begin
          frozen_flag_next   = 1'b1;
          result.sim_time_us = base_sim_us;
        end
      end
      OP_RESET: begin
        base_valid_next       = 1'b0;
        last_raw_next         = 32'd0;
        base_sim_us_next      = 64'd0;
        base_received_us_next = 64'd0;
        frozen_flag_next      = 1'b0;
        result.sim_time_us    = 64'd0;
      end
      default: begin
        // unused code: report only
      end
    endcase

    result.is_frozen = frozen_flag_next;
    result.has_base  = base_valid_next;
  end

  // timeout register write
  always_ff @(posedge clk) begin
    if (rst) begin
      freeze_timeout_us <= FREEZE_TIMEOUT_RST;
    end else if (cfg_we) begin
      freeze_timeout_us <= cfg_data;
    end
  end

  // state update once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      base_valid       <= 1'b0;
      last_frame       <= 32'd0;
      last_raw         <= 32'd0;
      base_sim_us      <= 64'd0;
      base_received_us <= 64'd0;
      frozen_flag      <= 1'b0;
    end else if (advance) begin
      base_valid       <= base_valid_next;
      last_frame       <= last_frame_next;
      last_raw         <= last_raw_next;
      base_sim_us      <= base_sim_us_next;
      base_received_us <= base_received_us_next;
      frozen_flag      <= frozen_flag_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/htu_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htu_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module htu_out_reg
  import htu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire htu_out_t result,
  output logic          hold,
  htu_chan_if.source    out_ch
);

  // full and not taken this cycle
  assign hold = out_ch.valid && !out_ch.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (!hold) begin
      out_ch.valid <= advance;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.payload <= result;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/host_time_unwrap_extrapolate_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// host_time_unwrap_extrapolate_core
// Unwraps 32-bit host stamps into a 64-bit sim time and extrapolates it.
// ----------------------------------------------------------------------------
// Channels: items enter on item_in (stamp, tick or session reset), one result
// per item leaves on result_out, and cfg writes the freeze timeout in us.
// All are valid/ready; a transfer happens when both are high at a clock edge.
// Path: an accepted item waits in the input register; one pass of the update
// logic then writes its result into the result register. Throughput: one item
// per cycle unless result_out is held; the session state is updated in the same
// pass that produces the result, so each item sees the previous one's state.
// Stalls: while result_out is held, the waiting item stays in the input
// register and item_in takes no more once that register is full.
// Reset (rst, synchronous): clears the session, the frame gate and both
// registers, and loads the default freeze timeout of 200000 us.
// cfg is always ready; write it only while no item is in flight.
// ----------------------------------------------------------------------------
module host_time_unwrap_extrapolate_core
  import htu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  htu_chan_if.sink   item_in,
  htu_chan_if.source result_out,
  htu_chan_if.sink   cfg
);

  logic     item_valid;
  htu_in_t  item;
  htu_out_t result;
  logic     hold;
  logic     advance;

  // item moves into the result register when that one is free
  assign advance   = item_valid && !hold;
  assign cfg.ready = 1'b1;

  htu_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  htu_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.payload),
    .advance  (advance),
    .item     (item),
    .result   (result)
  );

  htu_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .result  (result),
    .hold    (hold),
    .out_ch  (result_out)
  );

endmodule
`default_nettype wire
